[rtl/fac_pkg.sv]
// ---------------------------------------------------------------------------
// fac_pkg: shared types and codes for the fit allocator
// Request and result word layouts, request kinds, status and fit mode codes.
// ---------------------------------------------------------------------------
package fac_pkg;

    localparam int TAG_W   = 8;
    localparam int LEN_W   = 11;
    localparam int START_W = 10;

    typedef enum logic [1:0] {
        REQ_ALLOC   = 2'd0,
        REQ_FREE    = 2'd1,
        REQ_COMPACT = 2'd2,
        REQ_NONE    = 2'd3
    } req_type_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NO_HOLE  = 2'd1,
        ST_NO_TAG   = 2'd2,
        ST_FULL     = 2'd3
    } status_t;

    localparam logic [1:0] FIT_FIRST = 2'd0;
    localparam logic [1:0] FIT_BEST  = 2'd1;
    localparam logic [1:0] FIT_WORST = 2'd2;

    // result source select
    localparam logic [1:0] RSP_REQ   = 2'd0;  // allocate or free result
    localparam logic [1:0] RSP_MOVE  = 2'd1;  // held compact block
    localparam logic [1:0] RSP_EMPTY = 2'd2;  // compact with no blocks
    localparam logic [1:0] RSP_LAST  = 2'd3;  // held compact block, last

    typedef struct packed {
        logic [1:0]         req_type;
        logic [TAG_W-1:0]   owner_tag;
        logic [LEN_W-1:0]   req_length;
    } req_word_t;

    typedef struct packed {
        logic [1:0]         status;
        logic [START_W-1:0] block_start;
        logic [LEN_W-1:0]   block_length;
        logic [TAG_W-1:0]   block_tag;
        logic               last;
    } rsp_word_t;

    // controller -> datapath
    typedef struct packed {
        logic load_req;   // latch request, clear scan results
        logic scan_hole;  // examine hole at index
        logic scan_used;  // examine block at index
        logic alloc_do;   // commit allocation
        logic free_do;    // commit free
        logic cmp_scan;   // compact: find next block above cursor
        logic cmp_move;   // compact: relocate found block
        logic cmp_end;    // compact: rebuild hole table
    } dp_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic have_slot;
        logic have_hole;
        logic have_blk;
    } dp_sts_t;

endpackage

[rtl/fac_ctrl.sv]
// ---------------------------------------------------------------------------
// fac_ctrl: request sequencer
// Walks the hole and block tables one entry a cycle and drives the datapath.
// ---------------------------------------------------------------------------
module fac_ctrl
    import fac_pkg::*;
#(
    parameter int IDX_W = 5,
    parameter int HOLES = 17,
    parameter int BLKS  = 16
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             req_valid,
    output logic             req_ready,
    input  logic [1:0]       req_kind,
    input  logic             out_free,
    output logic             rsp_load,
    output logic             rsp_last,
    output logic [1:0]       rsp_sel,
    output dp_cmd_t          cmd,
    output logic [IDX_W-1:0] idx,
    input  dp_sts_t          sts
);

    typedef enum logic [3:0] {
        S_IDLE, S_AUSED, S_AHOLE, S_ACOMMIT, S_FUSED, S_FHOLE, S_FCOMMIT,
        S_CSCAN, S_CMOVE, S_RESP
    } state_t;

    state_t           state_reg, state_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic             cnt_any_reg, cnt_any_next;

    assign idx = idx_reg;
    assign req_ready = (state_reg == S_IDLE);

    always_comb begin
        state_next   = state_reg;
        idx_next     = idx_reg;
        cnt_any_next = cnt_any_reg;
        cmd          = '0;
        rsp_load     = 1'b0;
        rsp_last     = 1'b1;
        rsp_sel      = RSP_REQ;
        case (state_reg)
            S_IDLE: begin
                if (req_valid) begin
                    cmd.load_req = 1'b1;
                    idx_next     = '0;
                    cnt_any_next = 1'b0;
                    case (req_kind)
                        REQ_ALLOC:   state_next = S_AUSED;
                        REQ_FREE:    state_next = S_FUSED;
                        REQ_COMPACT: state_next = S_CSCAN;
                        default:     state_next = S_IDLE;
                    endcase
                end
            end
            S_AUSED: begin
                cmd.scan_used = 1'b1;
                if (idx_reg == IDX_W'(BLKS - 1)) begin
                    idx_next = '0;
                    state_next = S_AHOLE;
                end else begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            S_AHOLE: begin
                cmd.scan_hole = 1'b1;
                if (idx_reg == IDX_W'(HOLES - 1)) begin
                    state_next = S_ACOMMIT;
                end else begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            S_ACOMMIT: begin
                if (out_free) begin
                    cmd.alloc_do = 1'b1;
                    rsp_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_FUSED: begin
                cmd.scan_used = 1'b1;
                if (idx_reg == IDX_W'(BLKS - 1)) begin
                    idx_next = '0;
                    state_next = S_FHOLE;
                end else begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            S_FHOLE: begin
                cmd.scan_hole = 1'b1;
                if (idx_reg == IDX_W'(HOLES - 1)) begin
                    state_next = S_FCOMMIT;
                end else begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            S_FCOMMIT: begin
                if (out_free) begin
                    cmd.free_do = 1'b1;
                    rsp_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_CSCAN: begin
                cmd.cmp_scan = 1'b1;
                if (idx_reg == IDX_W'(BLKS - 1)) begin
                    idx_next = '0;
                    state_next = S_CMOVE;
                end else begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            S_CMOVE: begin
                if (sts.have_blk) begin
                    if (out_free) begin
                        cmd.cmp_move = 1'b1;
                        rsp_load     = 1'b1;
                        rsp_sel      = RSP_MOVE;
                        rsp_last     = 1'b0;
                        cnt_any_next = 1'b1;
                        state_next   = S_CSCAN;
                    end
                end else begin
                    cmd.cmp_end = 1'b1;
                    state_next  = S_RESP;
                end
            end
            S_RESP: begin
                // flush pending last or empty marker
                if (out_free) begin
                    rsp_load   = 1'b1;
                    rsp_sel    = cnt_any_reg ? RSP_LAST : RSP_EMPTY;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            idx_reg     <= '0;
            cnt_any_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            idx_reg     <= idx_next;
            cnt_any_reg <= cnt_any_next;
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_IDLE && req_valid && req_kind == REQ_ALLOC) |=> state_reg == S_AUSED)
        else $error("alloc did not start");
    assert property (@(posedge aclk) disable iff (!aresetn)
        rsp_load |-> out_free)
        else $error("result loaded into full register");
    assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({cmd.alloc_do, cmd.free_do, cmd.cmp_move, cmd.cmp_end}))
        else $error("conflicting commits");

endmodule

[rtl/fac_dp.sv]
// ---------------------------------------------------------------------------
// fac_dp: allocator tables and scan datapath
// Hole and block tables, one-entry-a-cycle compare units, commit logic.
// ---------------------------------------------------------------------------
module fac_dp
    import fac_pkg::*;
#(
    parameter int MEM_SIZE = 1024,
    parameter int BLKS     = 16,
    parameter int HOLES    = 17,
    parameter int IDX_W    = 5
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  req_word_t        req,
    input  logic [1:0]       fit_mode,
    input  dp_cmd_t          cmd,
    input  logic [IDX_W-1:0] idx,
    input  logic [1:0]       rsp_sel,
    input  logic             rsp_last,
    output dp_sts_t          sts,
    output rsp_word_t        rsp
);

    localparam int HI_W = $clog2(HOLES);
    localparam int BI_W = (BLKS > 1) ? $clog2(BLKS) : 1;
    localparam int AW   = $clog2(MEM_SIZE + 1);

    logic [AW-1:0]    hs_reg [HOLES];
    logic [AW-1:0]    hl_reg [HOLES];
    logic [HOLES-1:0] hv_reg;
    logic [AW-1:0]    us_reg [BLKS];
    logic [AW-1:0]    ul_reg [BLKS];
    logic [TAG_W-1:0] ut_reg [BLKS];
    logic [BLKS-1:0]  uv_reg;

    req_word_t        rq_reg;
    logic             slot_ok_reg, hole_ok_reg, blk_ok_reg, blw_ok_reg, abv_ok_reg;
    logic [BI_W-1:0]  slot_reg, blk_reg;
    logic [HI_W-1:0]  hole_reg, blw_reg, abv_reg, emp_reg;
    logic             emp_ok_reg;
    logic [AW-1:0]    top_reg;
    logic [AW:0]      cur_reg;    // compact cursor: next start must be >= cur

    logic [HI_W-1:0]  hi;
    logic [BI_W-1:0]  bi;
    logic [AW-1:0]    len_a;
    logic             take_hole, len_fit;

    assign hi = idx[HI_W-1:0];
    assign bi = idx[BI_W-1:0];
    assign len_a = rq_reg.req_length[AW-1:0];
    assign len_fit = (rq_reg.req_length != '0) &&
                     ({1'b0, rq_reg.req_length} <= (LEN_W+1)'(MEM_SIZE)) &&
                     (hl_reg[hi] >= len_a);

    always_comb begin
        take_hole = 1'b0;
        if (!hole_ok_reg) begin
            take_hole = 1'b1;
        end else if (fit_mode == FIT_FIRST) begin
            take_hole = hs_reg[hi] < hs_reg[hole_reg];
        end else if (fit_mode == FIT_WORST) begin
            take_hole = hl_reg[hi] > hl_reg[hole_reg] ||
                        (hl_reg[hi] == hl_reg[hole_reg] && hs_reg[hi] < hs_reg[hole_reg]);
        end else begin
            take_hole = hl_reg[hi] < hl_reg[hole_reg] ||
                        (hl_reg[hi] == hl_reg[hole_reg] && hs_reg[hi] < hs_reg[hole_reg]);
        end
    end

    logic          bi_ok;
    logic [AW-1:0] fs, fl;
    assign bi_ok = idx < IDX_W'(BLKS);
    assign fs = us_reg[blk_reg];
    assign fl = ul_reg[blk_reg];

    assign sts.have_slot = slot_ok_reg;
    assign sts.have_hole = hole_ok_reg;
    assign sts.have_blk  = blk_ok_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hv_reg    <= HOLES'(1);
            hs_reg[0] <= '0;
            hl_reg[0] <= AW'(MEM_SIZE);
            uv_reg    <= '0;
        end else begin
            if (cmd.load_req) begin
                rq_reg      <= req;
                slot_ok_reg <= 1'b0;
                hole_ok_reg <= 1'b0;
                blk_ok_reg  <= 1'b0;
                blw_ok_reg  <= 1'b0;
                abv_ok_reg  <= 1'b0;
                emp_ok_reg  <= 1'b0;
                top_reg     <= '0;
                cur_reg     <= '0;
            end
            if (cmd.scan_used && bi_ok) begin
                if (rq_reg.req_type == REQ_ALLOC) begin
                    if (!uv_reg[bi] && !slot_ok_reg) begin
                        slot_ok_reg <= 1'b1;
                        slot_reg    <= bi;
                    end
                end else if (uv_reg[bi] && ut_reg[bi] == rq_reg.owner_tag &&
                             (!blk_ok_reg || us_reg[bi] < us_reg[blk_reg])) begin
                    blk_ok_reg <= 1'b1;
                    blk_reg    <= bi;
                end
            end
            if (cmd.scan_hole) begin
                if (rq_reg.req_type == REQ_ALLOC) begin
                    if (hv_reg[hi] && len_fit && take_hole) begin
                        hole_ok_reg <= 1'b1;
                        hole_reg    <= hi;
                    end
                end else begin
                    if (hv_reg[hi]) begin
                        if ((AW+1)'(hs_reg[hi]) + (AW+1)'(hl_reg[hi]) == (AW+1)'(fs)) begin
                            blw_ok_reg <= 1'b1;
                            blw_reg    <= hi;
                        end else if ((AW+1)'(hs_reg[hi]) == (AW+1)'(fs) + (AW+1)'(fl)) begin
                            abv_ok_reg <= 1'b1;
                            abv_reg    <= hi;
                        end
                    end else if (!emp_ok_reg) begin
                        emp_ok_reg <= 1'b1;
                        emp_reg    <= hi;
                    end
                end
            end
            if (cmd.alloc_do && slot_ok_reg && hole_ok_reg) begin
                if (hl_reg[hole_reg] == len_a) begin
                    hv_reg[hole_reg] <= 1'b0;
                end else begin
                    hs_reg[hole_reg] <= hs_reg[hole_reg] + len_a;
                    hl_reg[hole_reg] <= hl_reg[hole_reg] - len_a;
                end
                us_reg[slot_reg] <= hs_reg[hole_reg];
                ul_reg[slot_reg] <= len_a;
                ut_reg[slot_reg] <= rq_reg.owner_tag;
                uv_reg[slot_reg] <= 1'b1;
            end
            if (cmd.free_do && blk_ok_reg) begin
                uv_reg[blk_reg] <= 1'b0;
                if (blw_ok_reg && abv_ok_reg) begin
                    hl_reg[blw_reg] <= hl_reg[blw_reg] + fl + hl_reg[abv_reg];
                    hv_reg[abv_reg] <= 1'b0;
                end else if (blw_ok_reg) begin
                    hl_reg[blw_reg] <= hl_reg[blw_reg] + fl;
                end else if (abv_ok_reg) begin
                    hs_reg[abv_reg] <= fs;
                    hl_reg[abv_reg] <= hl_reg[abv_reg] + fl;
                end else if (emp_ok_reg) begin
                    hs_reg[emp_reg] <= fs;
                    hl_reg[emp_reg] <= fl;
                    hv_reg[emp_reg] <= 1'b1;
                end
            end
            if (cmd.cmp_scan && bi_ok) begin
                if (uv_reg[bi] && {1'b0, us_reg[bi]} >= cur_reg &&
                    (!blk_ok_reg || us_reg[bi] < us_reg[blk_reg])) begin
                    blk_ok_reg <= 1'b1;
                    blk_reg    <= bi;
                end
            end
            if (cmd.cmp_move) begin
                us_reg[blk_reg] <= top_reg;
                top_reg         <= top_reg + ul_reg[blk_reg];
                cur_reg         <= (AW+1)'(top_reg) + (AW+1)'(ul_reg[blk_reg]);
                blk_ok_reg      <= 1'b0;
            end
            if (cmd.cmp_end) begin
                hv_reg    <= HOLES'(top_reg < AW'(MEM_SIZE));
                hs_reg[0] <= top_reg;
                hl_reg[0] <= AW'(MEM_SIZE) - top_reg;
            end
        end
    end

    // Result assembly. Compact results are held one step so the final one
    // can carry last; RSP_LAST releases the held one marked last.
    rsp_word_t held_reg;
    logic      held_ok_reg;

    always_comb begin
        rsp = '0;
        rsp.last = 1'b1;
        case (rq_reg.req_type)
            REQ_ALLOC: begin
                rsp.block_length = rq_reg.req_length;
                rsp.block_tag    = rq_reg.owner_tag;
                if (!slot_ok_reg) begin
                    rsp.status = ST_FULL;
                end else if (!hole_ok_reg) begin
                    rsp.status = ST_NO_HOLE;
                end else begin
                    rsp.status      = ST_OK;
                    rsp.block_start = START_W'(hs_reg[hole_reg]);
                end
            end
            REQ_FREE: begin
                rsp.block_tag = rq_reg.owner_tag;
                if (!blk_ok_reg) begin
                    rsp.status = ST_NO_TAG;
                end else begin
                    rsp.status       = ST_OK;
                    rsp.block_start  = START_W'(fs);
                    rsp.block_length = LEN_W'(fl);
                end
            end
            default: begin
                rsp = '0;
                rsp.last = 1'b1;
            end
        endcase
        if (rsp_sel == RSP_MOVE) begin
            rsp = held_reg;
            rsp.last = rsp_last;
        end else if (rsp_sel == RSP_LAST) begin
            rsp = held_reg;
            rsp.last = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_ok_reg <= 1'b0;
        end else if (cmd.load_req) begin
            held_ok_reg <= 1'b0;
        end else if (cmd.cmp_move) begin
            held_ok_reg            <= 1'b1;
            held_reg.status        <= ST_OK;
            held_reg.block_start   <= START_W'(top_reg);
            held_reg.block_length  <= LEN_W'(ul_reg[blk_reg]);
            held_reg.block_tag     <= ut_reg[blk_reg];
            held_reg.last          <= 1'b0;
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.alloc_do |-> !(slot_ok_reg && hole_ok_reg) || uv_reg[slot_reg] == 1'b0)
        else $error("allocating into a used slot");
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.cmp_move |-> blk_ok_reg)
        else $error("compact move without block");
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.cmp_move |-> held_ok_reg || cur_reg == '0)
        else $error("cursor moved before first block");

endmodule

[rtl/fit_allocator_with_coalesce.sv]
// ---------------------------------------------------------------------------
// fit_allocator_with_coalesce: first/best/worst fit region allocator
// Hole and block tables with adjacent coalescing on free and compaction.
// ---------------------------------------------------------------------------
// Allocate and free walk the block table, then the hole table, one table
// entry a cycle, then commit; the result is registered at the commit. Compact
// walks the block table once per block moved and once more to find none.
// One request at a time; a stalled output holds the commit.
// Synchronous active-low reset: one full hole, no blocks, first fit.
module fit_allocator_with_coalesce
    import fac_pkg::*;
#(
    parameter int MEM_SIZE   = 1024,
    parameter int MAX_BLOCKS = 16
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      cfg_we,
    input  logic [1:0] cfg_wdata,
    input  logic      s_valid,
    output logic      s_ready,
    input  req_word_t s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output rsp_word_t m_data
);

    localparam int HOLES = MAX_BLOCKS + 1;
    localparam int IDX_W = $clog2(HOLES);

    logic [1:0]       fit_reg;
    dp_cmd_t          cmd;
    dp_sts_t          sts;
    logic [IDX_W-1:0] idx;
    logic             rsp_load, rsp_last, out_free;
    logic [1:0]       rsp_sel;
    rsp_word_t        rsp;
    logic             m_valid_reg;
    rsp_word_t        m_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fit_reg <= FIT_FIRST;
        end else if (cfg_we) begin
            fit_reg <= cfg_wdata;
        end
    end

    assign out_free = !m_valid_reg || m_ready;

    fac_ctrl #(.IDX_W(IDX_W), .HOLES(HOLES), .BLKS(MAX_BLOCKS)) u_ctrl (
        .aclk, .aresetn,
        .req_valid(s_valid), .req_ready(s_ready), .req_kind(s_data.req_type),
        .out_free, .rsp_load, .rsp_last, .rsp_sel, .cmd, .idx, .sts
    );

    fac_dp #(.MEM_SIZE(MEM_SIZE), .BLKS(MAX_BLOCKS), .HOLES(HOLES), .IDX_W(IDX_W)) u_dp (
        .aclk, .aresetn, .req(s_data), .fit_mode(fit_reg), .cmd, .idx,
        .rsp_sel, .rsp_last, .sts, .rsp
    );

    // compact emits each block one step late: the move of block k sends k-1
    logic pend_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            pend_reg    <= 1'b0;
        end else begin
            if (cmd.load_req) pend_reg <= 1'b0;
            if (rsp_load && rsp_sel == RSP_MOVE) pend_reg <= 1'b1;
            if (rsp_load && !(rsp_sel == RSP_MOVE && !pend_reg)) begin
                m_valid_reg <= 1'b1;
                m_data_reg  <= rsp;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

[test/tb_top.sv]
// ---------------------------------------------------------------------------
// tb_top: testbench for the fit allocator
// Drives allocate, free and compact requests under all fit modes and checks
// every result word against a behavioral model of the hole and block tables.
// ---------------------------------------------------------------------------
module tb_top
    import fac_pkg::*;
();

    localparam int MEM   = 1024;
    localparam int NBLK  = 16;
    localparam int NHOLE = NBLK + 1;

    logic      aclk;
    logic      aresetn;
    logic      cfg_we;
    logic [1:0] cfg_wdata;
    logic      s_valid;
    logic      s_ready;
    req_word_t s_data;
    logic      m_valid;
    logic      m_ready;
    rsp_word_t m_data;

    fit_allocator_with_coalesce dut (
        .aclk(aclk), .aresetn(aresetn), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    // allocator model state
    int unsigned hs [NHOLE];
    int unsigned hl [NHOLE];
    bit          hv [NHOLE];
    int unsigned us [NBLK];
    int unsigned ul [NBLK];
    int unsigned ut [NBLK];
    bit          uv [NBLK];
    logic [1:0]  mode;

    rsp_word_t pending_rsp[$];
    int        mismatches;
    int        stall_hold;
    bit        rx_random;

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    initial begin
        #4000000;
        $display("TB_ERROR");
        $finish;
    end

    function automatic rsp_word_t mk(int unsigned st, int unsigned s, int unsigned l,
                                     int unsigned t, bit lst);
        rsp_word_t r;
        r.status       = st[1:0];
        r.block_start  = s[START_W-1:0];
        r.block_length = l[LEN_W-1:0];
        r.block_tag    = t[TAG_W-1:0];
        r.last         = lst;
        return r;
    endfunction

    function automatic void add_exp(rsp_word_t r);
        pending_rsp.insert(pending_rsp.size(), r);
    endfunction

    function automatic void model_reset();
        for (int i = 0; i < NHOLE; i++) begin
            hs[i] = 0; hl[i] = 0; hv[i] = 0;
        end
        for (int i = 0; i < NBLK; i++) begin
            us[i] = 0; ul[i] = 0; ut[i] = 0; uv[i] = 0;
        end
        hl[0] = MEM;
        hv[0] = 1;
        mode = FIT_FIRST;
    endfunction

    function automatic void predict_alloc(int unsigned tag, int unsigned len);
        int slot;
        int h;
        bit lower;
        bit take;
        slot = -1;
        h = -1;
        for (int i = NBLK - 1; i >= 0; i--)
            if (!uv[i]) slot = i;
        if (slot < 0) begin
            add_exp(mk(ST_FULL, 0, len, tag, 1'b1));
            return;
        end
        if (len != 0) begin
            for (int i = 0; i < NHOLE; i++) begin
                if (!hv[i] || hl[i] < len) continue;
                if (h < 0) begin
                    h = i;
                    continue;
                end
                lower = hs[i] < hs[h];
                if (mode == FIT_FIRST) take = lower;
                else if (mode == FIT_WORST) take = hl[i] > hl[h] || (hl[i] == hl[h] && lower);
                else take = hl[i] < hl[h] || (hl[i] == hl[h] && lower);
                if (take) h = i;
            end
        end
        if (h < 0) begin
            add_exp(mk(ST_NO_HOLE, 0, len, tag, 1'b1));
            return;
        end
        us[slot] = hs[h];
        ul[slot] = len;
        ut[slot] = tag;
        uv[slot] = 1;
        if (hl[h] == len) hv[h] = 0;
        else begin
            hs[h] += len;
            hl[h] -= len;
        end
        add_exp(mk(ST_OK, us[slot], len, tag, 1'b1));
    endfunction

    function automatic void predict_free(int unsigned tag);
        int b;
        int below;
        int above;
        int unsigned s;
        int unsigned len;
        b = -1;
        below = -1;
        above = -1;
        for (int i = 0; i < NBLK; i++)
            if (uv[i] && ut[i] == tag && (b < 0 || us[i] < us[b])) b = i;
        if (b < 0) begin
            add_exp(mk(ST_NO_TAG, 0, 0, tag, 1'b1));
            return;
        end
        s = us[b];
        len = ul[b];
        uv[b] = 0;
        for (int i = 0; i < NHOLE; i++) begin
            if (!hv[i]) continue;
            if (hs[i] + hl[i] == s) below = i;
            else if (hs[i] == s + len) above = i;
        end
        if (below >= 0 && above >= 0) begin
            hl[below] += len + hl[above];
            hv[above] = 0;
        end else if (below >= 0) begin
            hl[below] += len;
        end else if (above >= 0) begin
            hs[above] = s;
            hl[above] += len;
        end else begin
            for (int i = 0; i < NHOLE; i++) begin
                if (!hv[i]) begin
                    hs[i] = s; hl[i] = len; hv[i] = 1;
                    break;
                end
            end
        end
        add_exp(mk(ST_OK, s, len, tag, 1'b1));
    endfunction

    function automatic void predict_compact();
        int order[NBLK];
        int n;
        int j;
        int unsigned top;
        n = 0;
        top = 0;
        for (int i = 0; i < NBLK; i++) begin
            if (!uv[i]) continue;
            j = n;
            while (j > 0 && us[order[j-1]] > us[i]) begin
                order[j] = order[j-1];
                j--;
            end
            order[j] = i;
            n++;
        end
        for (int k = 0; k < n; k++) begin
            us[order[k]] = top;
            top += ul[order[k]];
            add_exp(mk(ST_OK, us[order[k]], ul[order[k]], ut[order[k]], k == n - 1));
        end
        for (int i = 0; i < NHOLE; i++) hv[i] = 0;
        if (top < MEM) begin
            hs[0] = top; hl[0] = MEM - top; hv[0] = 1;
        end
        if (n == 0) add_exp(mk(ST_OK, 0, 0, 0, 1'b1));
    endfunction

    function automatic void predict_request(req_word_t w);
        case (w.req_type)
            REQ_ALLOC:   predict_alloc(32'(w.owner_tag), 32'(w.req_length));
            REQ_FREE:    predict_free(32'(w.owner_tag));
            REQ_COMPACT: predict_compact();
            default: ;
        endcase
    endfunction

    task automatic send_word(logic [1:0] kind, logic [7:0] tag, logic [10:0] len);
        req_word_t w;
        w.req_type   = kind;
        w.owner_tag  = tag;
        w.req_length = len;
        s_valid = 1'b1;
        s_data  = w;
        do @(posedge aclk); while (!s_ready);
        predict_request(w);
        @(negedge aclk);
        s_valid = 1'b0;
    endtask

    // bursts of back-to-back words separated by random gaps
    int burst_left;
    task automatic pace();
        if (burst_left > 0) burst_left--;
        else begin
            repeat ($urandom_range(0, 60)) @(negedge aclk);
            burst_left = $urandom_range(0, 8);
        end
    endtask

    task automatic drain();
        while (pending_rsp.size() != 0) @(negedge aclk);
        repeat (700) @(negedge aclk);
    endtask

    task automatic set_mode(logic [1:0] m);
        drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= m;
        @(negedge aclk);
        cfg_we <= 1'b0;
        mode = m;
    endtask

    // receiver stall pattern
    always @(negedge aclk) begin
        if (stall_hold > 0) begin
            m_ready    <= 1'b0;
            stall_hold <= stall_hold - 1;
        end else if (rx_random) begin
            m_ready <= ($urandom_range(0, 3) != 0);
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        rsp_word_t exp_w;
        if (aresetn && m_valid && m_ready) begin
            if (pending_rsp.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected word exp none got %h", m_data);
            end else begin
                exp_w = pending_rsp.pop_front();
                if (m_data !== exp_w) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"mismatch exp st=%0d s=%0d l=%0d t=%0d last=%0b",
                                  " got st=%0d s=%0d l=%0d t=%0d last=%0b"},
                                 exp_w.status, exp_w.block_start, exp_w.block_length,
                                 exp_w.block_tag, exp_w.last, m_data.status,
                                 m_data.block_start, m_data.block_length,
                                 m_data.block_tag, m_data.last);
                end
            end
        end
    end

    task automatic test_directed();
        send_word(REQ_COMPACT, 8'd0, 11'd0);
        send_word(REQ_ALLOC, 8'h41, 11'd0);
        send_word(REQ_ALLOC, 8'hFF, 11'd1025);
        send_word(REQ_ALLOC, 8'h00, 11'd2047);
        send_word(REQ_FREE, 8'h7E, 11'd0);
        send_word(REQ_NONE, 8'hAA, 11'h555);
        send_word(REQ_ALLOC, 8'h41, 11'd100);
        send_word(REQ_ALLOC, 8'h42, 11'd200);
        send_word(REQ_ALLOC, 8'h41, 11'd50);
        send_word(REQ_ALLOC, 8'h43, 11'd300);
        send_word(REQ_FREE, 8'h42, 11'd0);
        send_word(REQ_FREE, 8'h41, 11'd0);
        send_word(REQ_FREE, 8'h41, 11'd0);
        send_word(REQ_COMPACT, 8'd0, 11'd0);
        send_word(REQ_ALLOC, 8'hFF, 11'd724);
        send_word(REQ_COMPACT, 8'd0, 11'd0);
        send_word(REQ_FREE, 8'h43, 11'd0);
        send_word(REQ_FREE, 8'hFF, 11'd0);
        send_word(REQ_ALLOC, 8'h01, 11'd1024);
        send_word(REQ_COMPACT, 8'd0, 11'd0);
        send_word(REQ_FREE, 8'h01, 11'd0);
    endtask

    task automatic test_table_full();
        for (int i = 0; i < NBLK + 1; i++) send_word(REQ_ALLOC, i[7:0], 11'd10);
        for (int i = 0; i < NBLK; i += 2) send_word(REQ_FREE, i[7:0], 11'd0);
        send_word(REQ_ALLOC, 8'h20, 11'd15);
        send_word(REQ_ALLOC, 8'h21, 11'd5);
        send_word(REQ_COMPACT, 8'd0, 11'd0);
        for (int i = 0; i < 34; i++) send_word(REQ_FREE, i[7:0], 11'd0);
    endtask

    task automatic random_word();
        int r;
        logic [10:0] len;
        r = $urandom_range(0, 99);
        if ($urandom_range(0, 9) == 0) len = 11'($urandom);
        else len = 11'($urandom_range(1, 160));
        if (r < 55) send_word(REQ_ALLOC, 8'($urandom_range(0, 23)), len);
        else if (r < 85) send_word(REQ_FREE, 8'($urandom_range(0, 23)), len);
        else if (r < 93) send_word(REQ_COMPACT, 8'($urandom), 11'($urandom));
        else if (r < 97) send_word(REQ_ALLOC, 8'($urandom), 11'($urandom));
        else send_word(REQ_NONE, 8'($urandom), 11'($urandom));
    endtask

    task automatic test_random(int count);
        for (int i = 0; i < count; i++) begin
            pace();
            random_word();
        end
    endtask

    task automatic test_backpressure();
        stall_hold = 2000;
        for (int i = 0; i < 6; i++) random_word();
        drain();
    endtask

    initial begin
        aresetn   = 1'b0;
        cfg_we    = 1'b0;
        cfg_wdata = 2'd0;
        s_valid   = 1'b0;
        s_data    = '0;
        m_ready   = 1'b0;
        stall_hold = 0;
        rx_random  = 1'b0;
        mismatches = 0;
        burst_left = 0;
        model_reset();
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        repeat (600) @(negedge aclk);

        test_directed();
        set_mode(FIT_WORST);
        test_table_full();
        rx_random = 1'b1;
        set_mode(FIT_FIRST);
        test_random(5);
        set_mode(FIT_BEST);
        test_random(5);
        test_backpressure();
        set_mode(FIT_WORST);
        test_random(5);
        set_mode(2'd3);
        test_random(5);
        rx_random = 1'b0;
        test_random(4);
        drain();

        if (mismatches == 0) $display("TB_OK");
        else $display("TB_ERROR");
        $finish;
    end
endmodule

[filelist.f]
rtl/fac_pkg.sv
rtl/fac_ctrl.sv
rtl/fac_dp.sv
rtl/fit_allocator_with_coalesce.sv
test/tb_top.sv
